// ===== hw/rtl/jit_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jit_pkg: shared types and constants of the job id table
// Command codes, controller states, field widths and parameter defaults.
// ----------------------------------------------------------------------------
package jit_pkg;

	localparam int SLOTS_DEF      = 16;
	localparam int PID_BITS_DEF   = 22;

	localparam int PID_PORT_BITS  = 22;
	localparam int JOB_PORT_BITS  = 5;
	localparam int STATE_BITS     = 2;
	localparam int CMD_BITS       = 3;
	// job ids can climb past the port range through repeated deletes
	localparam int JOB_STORE_BITS = 32;

	localparam logic [STATE_BITS-1:0] RUN_FG = 2'd1;

	typedef enum logic [CMD_BITS-1:0] {
		CMD_ADD      = 3'd0,
		CMD_DELETE   = 3'd1,
		CMD_SET      = 3'd2,
		CMD_FIND_PID = 3'd3,
		CMD_FIND_JOB = 3'd4,
		CMD_FIND_FG  = 3'd5
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} ctrl_state_t;

endpackage

// ===== hw/rtl/job_id_table_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// job_id_table_top: job slot table with job id allocation
// A ring of SLOTS slot cells rotates once per command past a head controller
// that adds, deletes, edits or looks up slots by pid, job id or foreground.
// ----------------------------------------------------------------------------
//
//   channel  handshake              payload
//   -------  ---------------------  -------------------------------------------
//   input    in_valid / in_stall    cmd, proc_id, job_id, new_state
//   result   out_valid / out_stall  ok, proc_id_out, job_id_out, state_out
//
// Each command is accepted, then the ring shifts one slot per cycle past the
// head until all SLOTS slots have been seen, then the result register is
// loaded. in_stall is low only while the controller is idle; an item may
// be accepted while the previous result still waits, and its result is
// held until the result register is free.
// Reset clears every slot and sets the next job id to 1.
// ----------------------------------------------------------------------------
module job_id_table_top #(
	parameter int SLOTS    = jit_pkg::SLOTS_DEF,
	parameter int PID_BITS = jit_pkg::PID_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [jit_pkg::CMD_BITS-1:0]       cmd,
	input  logic [jit_pkg::PID_PORT_BITS-1:0]  proc_id,
	input  logic [jit_pkg::JOB_PORT_BITS-1:0]  job_id,
	input  logic [jit_pkg::STATE_BITS-1:0]     new_state,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               ok,
	output logic [jit_pkg::PID_PORT_BITS-1:0]  proc_id_out,
	output logic [jit_pkg::JOB_PORT_BITS-1:0]  job_id_out,
	output logic [jit_pkg::STATE_BITS-1:0]     state_out
);

	// only the low PID_BITS of the pid port take part
	localparam int PW = (PID_BITS < jit_pkg::PID_PORT_BITS) ? PID_BITS
	                                                        : jit_pkg::PID_PORT_BITS;
	localparam int JB = jit_pkg::JOB_STORE_BITS;

	// cell i hands its slot to cell i-1; the tail takes the edited head
	logic [PW-1:0]                  ring_proc  [SLOTS+1];
	logic [JB-1:0]                  ring_job   [SLOTS+1];
	logic [jit_pkg::STATE_BITS-1:0] ring_state [SLOTS+1];

	logic          shift;
	logic [PW-1:0] res_proc;

	genvar gi;
	generate
		for (gi = 0; gi < SLOTS; gi++) begin : g_cell
			jit_cell #(
				.PW (PW)
			) u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.shift   (shift),
				.d_proc  (ring_proc[gi+1]),
				.d_job   (ring_job[gi+1]),
				.d_state (ring_state[gi+1]),
				.q_proc  (ring_proc[gi]),
				.q_job   (ring_job[gi]),
				.q_state (ring_state[gi])
			);
		end
	endgenerate

	jit_ctrl #(
		.SLOTS (SLOTS),
		.PW    (PW)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.cmd        (cmd),
		.pid        (proc_id[PW-1:0]),
		.jid        (job_id),
		.new_state  (new_state),
		.head_proc  (ring_proc[0]),
		.head_job   (ring_job[0]),
		.head_state (ring_state[0]),
		.shift      (shift),
		.wb_proc    (ring_proc[SLOTS]),
		.wb_job     (ring_job[SLOTS]),
		.wb_state   (ring_state[SLOTS]),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.ok         (ok),
		.res_proc   (res_proc),
		.res_job    (job_id_out),
		.res_state  (state_out)
	);

	// widen the stored pid back to the port
	assign proc_id_out = jit_pkg::PID_PORT_BITS'(res_proc);

endmodule

// ===== hw/rtl/jit_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jit_cell: one job slot of the rotating table
// Holds pid, job id and run state; takes its neighbor's slot on shift.
// ----------------------------------------------------------------------------
module jit_cell #(
	parameter int PW = jit_pkg::PID_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                shift,
	input  logic [PW-1:0]                       d_proc,
	input  logic [jit_pkg::JOB_STORE_BITS-1:0]  d_job,
	input  logic [jit_pkg::STATE_BITS-1:0]      d_state,
	output logic [PW-1:0]                       q_proc,
	output logic [jit_pkg::JOB_STORE_BITS-1:0]  q_job,
	output logic [jit_pkg::STATE_BITS-1:0]      q_state
);

	logic [PW-1:0]                      proc_q;
	logic [jit_pkg::JOB_STORE_BITS-1:0] job_q;
	logic [jit_pkg::STATE_BITS-1:0]     state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			proc_q  <= '0;
			job_q   <= '0;
			state_q <= '0;
		end else if (shift) begin
			proc_q  <= d_proc;
			job_q   <= d_job;
			state_q <= d_state;
		end
	end

	assign q_proc  = proc_q;
	assign q_job   = job_q;
	assign q_state = state_q;

endmodule

// ===== hw/rtl/jit_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jit_ctrl: head of the slot ring and command sequencer
// Examines the slot at the head each scan cycle, writes back the edited slot
// at the tail, tracks first match and largest job id, drives the handshakes.
// ----------------------------------------------------------------------------
module jit_ctrl #(
	parameter int SLOTS = jit_pkg::SLOTS_DEF,
	parameter int PW    = jit_pkg::PID_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// input channel
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [jit_pkg::CMD_BITS-1:0]        cmd,
	input  logic [PW-1:0]                       pid,
	input  logic [jit_pkg::JOB_PORT_BITS-1:0]   jid,
	input  logic [jit_pkg::STATE_BITS-1:0]      new_state,
	// ring head and tail
	input  logic [PW-1:0]                       head_proc,
	input  logic [jit_pkg::JOB_STORE_BITS-1:0]  head_job,
	input  logic [jit_pkg::STATE_BITS-1:0]      head_state,
	output logic                                shift,
	output logic [PW-1:0]                       wb_proc,
	output logic [jit_pkg::JOB_STORE_BITS-1:0]  wb_job,
	output logic [jit_pkg::STATE_BITS-1:0]      wb_state,
	// result channel
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                ok,
	output logic [PW-1:0]                       res_proc,
	output logic [jit_pkg::JOB_PORT_BITS-1:0]   res_job,
	output logic [jit_pkg::STATE_BITS-1:0]      res_state
);

	localparam int CW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam logic [CW-1:0] CNT_LAST = CW'(SLOTS - 1);
	localparam int JB = jit_pkg::JOB_STORE_BITS;

	jit_pkg::ctrl_state_t state_q, state_d;

	jit_pkg::cmd_t                      cmd_q;
	logic [PW-1:0]                      pid_q;
	logic [jit_pkg::JOB_PORT_BITS-1:0]  jid_q;
	logic [jit_pkg::STATE_BITS-1:0]     st_q;
	logic [CW-1:0]                      cnt_q;
	logic                               hit_q;
	logic [JB-1:0]                      max_q;
	logic [JB-1:0]                      next_q;
	logic [PW-1:0]                      rp_q;
	logic [JB-1:0]                      rj_q;
	logic [jit_pkg::STATE_BITS-1:0]     rs_q;

	logic                               out_valid_q;
	logic                               ok_q;
	logic [PW-1:0]                      op_q;
	logic [jit_pkg::JOB_PORT_BITS-1:0]  oj_q;
	logic [jit_pkg::STATE_BITS-1:0]     os_q;

	logic          accept, scan, last, load_out, out_free;
	logic          match, first;
	logic [JB-1:0] max_nx, add_nx;
	logic [PW-1:0] cap_proc;
	logic [JB-1:0] cap_job;
	logic [jit_pkg::STATE_BITS-1:0] cap_state;

	assign out_free = !out_valid_q || !out_stall;
	assign last     = (cnt_q == CNT_LAST);

	// sequencer
	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		accept   = 1'b0;
		scan     = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			jit_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					accept  = 1'b1;
					state_d = jit_pkg::ST_SCAN;
				end
			end
			jit_pkg::ST_SCAN: begin
				scan = 1'b1;
				if (last) begin
					state_d = jit_pkg::ST_DONE;
				end
			end
			jit_pkg::ST_DONE: begin
				if (out_free) begin
					load_out = 1'b1;
					state_d  = jit_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = jit_pkg::ST_IDLE;
			end
		endcase
	end

	assign shift = scan;

	// head slot test and edit
	always_comb begin
		match    = 1'b0;
		wb_proc  = head_proc;
		wb_job   = head_job;
		wb_state = head_state;
		unique case (cmd_q)
			jit_pkg::CMD_ADD:      match = (pid_q != '0) && (head_proc == '0);
			jit_pkg::CMD_DELETE,
			jit_pkg::CMD_SET,
			jit_pkg::CMD_FIND_PID: match = (pid_q != '0) && (head_proc == pid_q);
			jit_pkg::CMD_FIND_JOB: match = (jid_q != '0) && (head_job == JB'(jid_q));
			jit_pkg::CMD_FIND_FG:  match = (head_state == jit_pkg::RUN_FG);
			default:               match = 1'b0;
		endcase
		first = match && !hit_q;
		if (first) begin
			unique case (cmd_q)
				jit_pkg::CMD_ADD: begin
					wb_proc  = pid_q;
					wb_job   = next_q;
					wb_state = st_q;
				end
				jit_pkg::CMD_DELETE: begin
					wb_proc  = '0;
					wb_job   = '0;
					wb_state = '0;
				end
				jit_pkg::CMD_SET: begin
					wb_state = st_q;
				end
				default: begin
				end
			endcase
		end
		// delete reports the slot before it was cleared
		if (cmd_q == jit_pkg::CMD_DELETE) begin
			cap_proc  = head_proc;
			cap_job   = head_job;
			cap_state = head_state;
		end else begin
			cap_proc  = wb_proc;
			cap_job   = wb_job;
			cap_state = wb_state;
		end
		max_nx = (wb_job > max_q) ? wb_job : max_q;
		add_nx = next_q + JB'(1);
		if (add_nx > JB'(SLOTS)) begin
			add_nx = JB'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= jit_pkg::ST_IDLE;
			cnt_q       <= '0;
			hit_q       <= 1'b0;
			next_q      <= JB'(1);
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				cnt_q <= '0;
				hit_q <= 1'b0;
			end else if (scan) begin
				cnt_q <= cnt_q + CW'(1);
				if (match) begin
					hit_q <= 1'b1;
				end
				if (last) begin
					if (cmd_q == jit_pkg::CMD_ADD && (hit_q || match)) begin
						next_q <= add_nx;
					end else if (cmd_q == jit_pkg::CMD_DELETE && (hit_q || match)) begin
						next_q <= max_nx + JB'(1);
					end
				end
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= jit_pkg::cmd_t'(cmd);
			pid_q <= pid;
			jid_q <= jid;
			st_q  <= new_state;
			max_q <= '0;
			rp_q  <= '0;
			rj_q  <= '0;
			rs_q  <= '0;
		end else if (scan) begin
			max_q <= max_nx;
			if (first) begin
				rp_q <= cap_proc;
				rj_q <= cap_job;
				rs_q <= cap_state;
			end
		end
		if (load_out) begin
			ok_q <= hit_q;
			op_q <= rp_q;
			oj_q <= rj_q[jit_pkg::JOB_PORT_BITS-1:0];
			os_q <= rs_q;
		end
	end

	assign out_valid = out_valid_q;
	assign ok        = ok_q;
	assign res_proc  = op_q;
	assign res_job   = oj_q;
	assign res_state = os_q;

endmodule

// ===== tb/tb_job_id_table_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_job_id_table_top: self-checking bench for the job id table
// Drives add, delete, set state, the three finds and unused codes through
// the input channel, predicts every result from a private copy of the slot
// table, checks each result field by field, under random idling on both sides.
// ----------------------------------------------------------------------------
module tb_job_id_table_top;

	localparam int TABLE_SLOTS  = jit_pkg::SLOTS_DEF;
	localparam int PID_W        = jit_pkg::PID_PORT_BITS;
	localparam int CMD_W        = jit_pkg::CMD_BITS;
	localparam int JID_W        = jit_pkg::JOB_PORT_BITS;
	localparam int JOB_W        = jit_pkg::JOB_STORE_BITS;
	localparam int ST_W         = jit_pkg::STATE_BITS;
	localparam int LIMIT_CYCLES = 400000;
	localparam int RANDOM_ITEMS = 650;
	localparam int PHASES       = 6;
	localparam int PID_POOL     = 24;
	localparam int MAX_REPORTS  = 10;

	// codes the block does not decode; they must come back empty
	localparam logic [CMD_W-1:0] CMD_UNUSED_A = 3'd6;
	localparam logic [CMD_W-1:0] CMD_UNUSED_B = 3'd7;

	localparam logic [ST_W-1:0] STATE_UNDEF = 2'd0;
	localparam logic [ST_W-1:0] STATE_FG    = jit_pkg::RUN_FG;
	localparam logic [ST_W-1:0] STATE_BG    = 2'd2;
	localparam logic [ST_W-1:0] STATE_STOP  = 2'd3;

	localparam logic [PID_W-1:0] PID_MAX = {PID_W{1'b1}};

	typedef struct packed {
		logic [CMD_W-1:0] c;
		logic             ok;
		logic [PID_W-1:0] pid;
		logic [JID_W-1:0] jid;
		logic [ST_W-1:0]  st;
	} job_result_t;

	// Slot table predictor plus the queue of results still owed by the block.
	class job_table_scoreboard;
		logic [PID_W-1:0] proc_tab[TABLE_SLOTS];
		logic [JOB_W-1:0] job_tab[TABLE_SLOTS];
		logic [ST_W-1:0]  state_tab[TABLE_SLOTS];
		logic [JOB_W-1:0] next_id;
		logic [JOB_W-1:0] peak_id;
		job_result_t      awaited[$];
		int               mismatches;
		int               checked;
		int               full_rejects;
		int               cmds[8];
		int               hits[8];

		function new();
			for (int i = 0; i < TABLE_SLOTS; i++) begin
				proc_tab[i]  = '0;
				job_tab[i]   = '0;
				state_tab[i] = '0;
			end
			next_id      = 1;
			peak_id      = 1;
			mismatches   = 0;
			checked      = 0;
			full_rejects = 0;
			for (int i = 0; i < 8; i++) begin
				cmds[i] = 0;
				hits[i] = 0;
			end
		endfunction

		function int first_slot(logic [PID_W-1:0] pid);
			for (int i = 0; i < TABLE_SLOTS; i++)
				if (proc_tab[i] == pid)
					return i;
			return -1;
		endfunction

		function int pending();
			return awaited.size();
		endfunction

		// Apply one accepted command to the table and queue its result.
		function void note_input(logic [CMD_W-1:0] c, logic [PID_W-1:0] pid,
				logic [JID_W-1:0] jid, logic [ST_W-1:0] st);
			int               hit;
			int               i;
			logic [JOB_W-1:0] top;
			job_result_t      r;
			hit = -1;
			r = '0;
			r.c = c;
			cmds[c]++;
			case (c)
				jit_pkg::CMD_ADD: begin
					if (pid != 0) begin
						hit = first_slot('0);
						if (hit >= 0) begin
							proc_tab[hit]  = pid;
							state_tab[hit] = st;
							job_tab[hit]   = next_id;
							next_id        = next_id + 1;
							if (next_id > TABLE_SLOTS)
								next_id = 1;
						end else begin
							full_rejects++;
						end
					end
				end
				jit_pkg::CMD_DELETE: begin
					if (pid != 0) begin
						hit = first_slot(pid);
						if (hit >= 0) begin
							// report the slot as it stood before clearing
							r.pid = proc_tab[hit];
							r.jid = job_tab[hit][JID_W-1:0];
							r.st  = state_tab[hit];
							proc_tab[hit]  = '0;
							job_tab[hit]   = '0;
							state_tab[hit] = '0;
							top = '0;
							for (i = 0; i < TABLE_SLOTS; i++)
								if (job_tab[i] > top)
									top = job_tab[i];
							next_id = top + 1;
						end
					end
				end
				jit_pkg::CMD_SET: begin
					if (pid != 0) begin
						hit = first_slot(pid);
						if (hit >= 0)
							state_tab[hit] = st;
					end
				end
				jit_pkg::CMD_FIND_PID: begin
					if (pid != 0)
						hit = first_slot(pid);
				end
				jit_pkg::CMD_FIND_JOB: begin
					if (jid != 0)
						for (i = 0; i < TABLE_SLOTS; i++)
							if (hit < 0 && job_tab[i] == JOB_W'(jid))
								hit = i;
				end
				jit_pkg::CMD_FIND_FG: begin
					for (i = 0; i < TABLE_SLOTS; i++)
						if (hit < 0 && state_tab[i] == jit_pkg::RUN_FG)
							hit = i;
				end
				default: ;
			endcase
			if (hit >= 0) begin
				r.ok = 1'b1;
				hits[c]++;
				if (c != jit_pkg::CMD_DELETE) begin
					r.pid = proc_tab[hit];
					r.jid = job_tab[hit][JID_W-1:0];
					r.st  = state_tab[hit];
				end
			end
			if (next_id > peak_id)
				peak_id = next_id;
			awaited.push_back(r);
		endfunction

		// Compare one result item against the oldest expectation.
		function void check_result(logic ok, logic [PID_W-1:0] pid,
				logic [JID_W-1:0] jid, logic [ST_W-1:0] st);
			job_result_t e;
			checked++;
			if (awaited.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: unexpected result: ok %0d pid %h job %0d state %0d",
						$time, ok, pid, jid, st);
				return;
			end
			e = awaited.pop_front();
			if (ok !== e.ok || pid !== e.pid || jid !== e.jid || st !== e.st) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS) begin
					$display("%0t: cmd %0d mismatch, expected ok %0d pid %h job %0d state %0d",
						$time, e.c, e.ok, e.pid, e.jid, e.st);
					$display("%0t: cmd %0d mismatch, got      ok %0d pid %h job %0d state %0d",
						$time, e.c, ok, pid, jid, st);
				end
			end
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_stall;
	logic [CMD_W-1:0] cmd = '0;
	logic [PID_W-1:0] proc_id = '0;
	logic [JID_W-1:0] job_id = '0;
	logic [ST_W-1:0]  new_state = '0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	logic             ok;
	logic [PID_W-1:0] proc_id_out;
	logic [JID_W-1:0] job_id_out;
	logic [ST_W-1:0]  state_out;

	job_table_scoreboard sb = new();

	// sender and receiver idling switches; set both for stretches at full rate
	bit tx_quiet = 1'b0;
	bit rx_quiet = 1'b0;
	int rx_hold = 0;
	int cycle_count = 0;
	logic [PID_W-1:0] pid_pool[PID_POOL];

	job_id_table_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.cmd         (cmd),
		.proc_id     (proc_id),
		.job_id      (job_id),
		.new_state   (new_state),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.ok          (ok),
		.proc_id_out (proc_id_out),
		.job_id_out  (job_id_out),
		.state_out   (state_out)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 85)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Note every accepted input item; payload is read before this edge's updates.
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			sb.note_input(cmd, proc_id, job_id, new_state);
	end

	// Check every accepted result item.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(ok, proc_id_out, job_id_out, state_out);
	end

	// Receiver: hold stall or open windows of random length.
	always @(posedge clk) begin
		if (rx_hold != 0) begin
			rx_hold <= rx_hold - 1;
		end else if (rx_quiet) begin
			out_stall <= 1'b0;
		end else if ($urandom_range(0, 3) == 0) begin
			out_stall <= 1'b1;
			rx_hold   <= pick_gap() - 1;
		end else begin
			out_stall <= 1'b0;
			rx_hold   <= $urandom_range(0, 5);
		end
	end

	// Watchdog: end the run if the block hangs.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("%0t: watchdog expired with %0d results still owed",
				$time, sb.pending());
			$display("job_id_table_top regression: fail");
			$finish;
		end
	end

	// Present one item, optionally after an idle gap, and hold it until accepted.
	task automatic send_item(input logic [CMD_W-1:0] c, input logic [PID_W-1:0] pid,
			input logic [JID_W-1:0] jid, input logic [ST_W-1:0] st);
		int gap;
		gap = (tx_quiet || $urandom_range(0, 1) == 0) ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		cmd       <= c;
		proc_id   <= pid;
		job_id    <= jid;
		new_state <= st;
		do
			@(posedge clk);
		while (in_stall);
	endtask

	// Drop valid and wait for every owed result to come back.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// Pick a pid: mostly from a small pool so commands hit live slots.
	function automatic logic [PID_W-1:0] pick_pid();
		int r;
		r = $urandom_range(0, 99);
		if (r < 6)
			return '0;
		if (r < 14)
			return PID_W'($urandom());
		return pid_pool[$urandom_range(0, PID_POOL - 1)];
	endfunction

	// One random item; add_pct and del_pct steer the table between full and empty.
	task automatic random_item(input int add_pct, input int del_pct, output bit counted);
		int               r;
		logic [CMD_W-1:0] c;
		r = $urandom_range(0, 99);
		counted = 1'b1;
		if (r < add_pct)
			c = jit_pkg::CMD_ADD;
		else if (r < add_pct + del_pct)
			c = jit_pkg::CMD_DELETE;
		else begin
			case ($urandom_range(0, 12))
				0, 1, 2:    c = jit_pkg::CMD_SET;
				3, 4, 5:    c = jit_pkg::CMD_FIND_PID;
				6, 7, 8:    c = jit_pkg::CMD_FIND_JOB;
				9, 10:      c = jit_pkg::CMD_FIND_FG;
				11:         c = CMD_UNUSED_A;
				default:    c = CMD_UNUSED_B;
			endcase
		end
		if (c == CMD_UNUSED_A || c == CMD_UNUSED_B) begin
			// noise: random fields, no effect on the table
			counted = 1'b0;
			send_item(c, PID_W'($urandom()), JID_W'($urandom()),
				ST_W'($urandom()));
		end else begin
			send_item(c, pick_pid(), JID_W'($urandom_range(0, 17)),
				ST_W'($urandom_range(0, 3)));
		end
	endtask

	initial begin
		int  useful;
		int  per_phase;
		int  add_pct;
		int  del_pct;
		int  total;
		bit  counted;

		pid_pool[0] = 1;
		pid_pool[1] = PID_MAX;
		pid_pool[2] = 2;
		for (int i = 3; i < PID_POOL; i++)
			pid_pool[i] = PID_W'($urandom_range(1, 32'h3FFFFF));

		// hold reset low at the start, then release it once for good
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty table, zero ids, duplicates, misses and unused codes.
		send_item(jit_pkg::CMD_FIND_FG,  '0,         5'd0,  STATE_UNDEF);
		send_item(jit_pkg::CMD_ADD,      '0,         5'd0,  STATE_FG);
		send_item(jit_pkg::CMD_ADD,      PID_MAX,    5'd0,  STATE_FG);
		send_item(jit_pkg::CMD_ADD,      22'd1,      5'd31, STATE_BG);
		send_item(jit_pkg::CMD_ADD,      22'd1,      5'd0,  STATE_STOP);
		send_item(jit_pkg::CMD_ADD,      22'h2AAAAA, 5'd0,  STATE_UNDEF);
		send_item(jit_pkg::CMD_FIND_PID, 22'd1,      5'd0,  STATE_UNDEF);
		send_item(jit_pkg::CMD_FIND_JOB, 22'd1,      5'd0,  STATE_UNDEF);
		send_item(jit_pkg::CMD_FIND_JOB, '0,         5'd3,  STATE_UNDEF);
		send_item(jit_pkg::CMD_FIND_JOB, '0,         5'd17, STATE_UNDEF);
		send_item(jit_pkg::CMD_SET,      22'd1,      5'd0,  STATE_FG);
		send_item(jit_pkg::CMD_SET,      '0,         5'd0,  STATE_STOP);
		send_item(jit_pkg::CMD_SET,      22'd5,      5'd0,  STATE_BG);
		send_item(jit_pkg::CMD_FIND_FG,  '0,         5'd0,  STATE_UNDEF);
		send_item(jit_pkg::CMD_DELETE,   '0,         5'd0,  STATE_UNDEF);
		send_item(jit_pkg::CMD_DELETE,   22'd7,      5'd0,  STATE_UNDEF);
		send_item(jit_pkg::CMD_DELETE,   22'd1,      5'd0,  STATE_UNDEF);
		send_item(jit_pkg::CMD_FIND_PID, 22'd1,      5'd0,  STATE_UNDEF);
		send_item(jit_pkg::CMD_FIND_PID, '0,         5'd0,  STATE_UNDEF);
		send_item(CMD_UNUSED_A,          22'd1,      5'd1,  STATE_FG);
		send_item(CMD_UNUSED_B,          PID_MAX,    5'd31, STATE_STOP);
		send_item(jit_pkg::CMD_DELETE,   PID_MAX,    5'd0,  STATE_UNDEF);
		send_item(jit_pkg::CMD_FIND_PID, 22'h155555, 5'd0,  STATE_UNDEF);
		// pause the sender until the table has answered everything
		drain();

		// Random phases cycle through filling (table full, id wrap), emptying
		// (delete recomputes the next id, which can climb) and a balanced mix.
		per_phase = RANDOM_ITEMS / PHASES;
		for (int p = 0; p < PHASES; p++) begin
			case (p % 3)
				0:       begin add_pct = 55; del_pct = 12; end
				1:       begin add_pct = 20; del_pct = 40; end
				default: begin add_pct = 35; del_pct = 25; end
			endcase
			// run one phase with no idling on either side
			tx_quiet = (p == 2);
			rx_quiet = (p == 2);
			useful = 0;
			while (useful < per_phase) begin
				random_item(add_pct, del_pct, counted);
				if (counted)
					useful++;
			end
			drain();
		end
		tx_quiet = 1'b0;
		rx_quiet = 1'b0;

		// let any stray result show up before the verdict
		repeat (2 * (TABLE_SLOTS + 2)) @(posedge clk);

		total = 0;
		for (int i = 0; i < 8; i++)
			total += sb.cmds[i];
		$write("ran %0d commands, %0d results checked in %0d cycles; ",
			total, sb.checked, cycle_count);
		$display("table full on %0d adds, next id peaked at %0d",
			sb.full_rejects, sb.peak_id);
		$write("hits: add %0d/%0d delete %0d/%0d set %0d/%0d ",
			sb.hits[0], sb.cmds[0], sb.hits[1], sb.cmds[1], sb.hits[2], sb.cmds[2]);
		$display("pid %0d/%0d job %0d/%0d fg %0d/%0d, unused %0d",
			sb.hits[3], sb.cmds[3], sb.hits[4], sb.cmds[4], sb.hits[5], sb.cmds[5],
			sb.cmds[6] + sb.cmds[7]);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("job_id_table_top regression: pass");
		end else begin
			$display("%0d mismatches, %0d results never arrived",
				sb.mismatches, sb.pending());
			$display("job_id_table_top regression: fail");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/jit_pkg.sv
hw/rtl/jit_cell.sv
hw/rtl/jit_ctrl.sv
hw/rtl/job_id_table_top.sv
tb/tb_job_id_table_top.sv
